// File: rtl/core/sacache_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Set-associative cache package
// Shared constants, types and helpers for the cache model core.
// ----------------------------------------------------------------------------
package sacache_pkg;

    localparam int MAX_SETS   = 64;
    localparam int MAX_WAYS   = 4;
    localparam int ADDR_WIDTH = 48;

    localparam int SET_W   = $clog2(MAX_SETS);
    localparam int WAY_W   = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
    localparam int STAMP_W = 40;
    localparam int TOTAL_W = 32;
    localparam int OFFS_MAX = 12;

    localparam logic [STAMP_W-1:0] STAMP_MAX = {STAMP_W{1'b1}};
    localparam logic [TOTAL_W-1:0] TOTAL_MAX = {TOTAL_W{1'b1}};

    localparam logic [2:0] REG_OFFSET_BITS = 3'd0;
    localparam logic [2:0] REG_SET_BITS    = 3'd1;
    localparam logic [2:0] REG_WAYS        = 3'd2;
    localparam logic [2:0] REG_LRU_MODE    = 3'd3;
    localparam logic [2:0] REG_PREFETCH    = 3'd4;

    typedef struct packed {
        logic                  valid;
        logic [ADDR_WIDTH-1:0] tag;
        logic [STAMP_W-1:0]    stamp;
    } line_t;

    typedef line_t [MAX_WAYS-1:0] set_line_t;

    typedef struct packed {
        logic [3:0] offset_bits;
        logic [2:0] set_bits;
        logic [2:0] ways_in_use;
        logic       lru_mode;
        logic       prefetch_enable;
    } cfg_t;

    function automatic logic [TOTAL_W-1:0] sat_inc(input logic [TOTAL_W-1:0] v);
        sat_inc = (v == TOTAL_MAX) ? v : v + 1'b1;
    endfunction

endpackage
`default_nettype wire

// File: rtl/core/sacache_cfg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Cache configuration registers
// APB-style register file holding geometry and policy settings.
// ----------------------------------------------------------------------------
module sacache_cfg (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 psel,
    input  wire logic                 penable,
    input  wire logic                 pwrite,
    input  wire logic [4:0]           paddr,
    input  wire logic [31:0]          pwdata,
    output logic [31:0]               prdata,
    output logic                      pready,
    output sacache_pkg::cfg_t         cfg
);
    import sacache_pkg::*;

    cfg_t cfg_reg;

    assign pready = 1'b1;
    assign cfg    = cfg_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg <= '{offset_bits: 4'd6, set_bits: 3'd4, ways_in_use: 3'd4,
                         lru_mode: 1'b0, prefetch_enable: 1'b0};
        end else if (psel && penable && pwrite) begin
            unique case (paddr[4:2])
                REG_OFFSET_BITS: cfg_reg.offset_bits     <= pwdata[3:0];
                REG_SET_BITS:    cfg_reg.set_bits        <= pwdata[2:0];
                REG_WAYS:        cfg_reg.ways_in_use     <= pwdata[2:0];
                REG_LRU_MODE:    cfg_reg.lru_mode        <= pwdata[0];
                REG_PREFETCH:    cfg_reg.prefetch_enable <= pwdata[0];
                default: ;
            endcase
        end
    end

    always_comb begin
        prdata = '0;
        unique case (paddr[4:2])
            REG_OFFSET_BITS: prdata[3:0] = cfg_reg.offset_bits;
            REG_SET_BITS:    prdata[2:0] = cfg_reg.set_bits;
            REG_WAYS:        prdata[2:0] = cfg_reg.ways_in_use;
            REG_LRU_MODE:    prdata[0]   = cfg_reg.lru_mode;
            REG_PREFETCH:    prdata[0]   = cfg_reg.prefetch_enable;
            default:         prdata      = '0;
        endcase
    end

    logic unused_bits;
    assign unused_bits = ^{paddr[1:0], pwdata[31:4]};

endmodule
`default_nettype wire

// File: rtl/core/sacache_set_mem.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Cache set memory
// One row per set holding tag and stamp of every way; valid bits kept in
// flip-flops so that reset clears all lines at once.
// ----------------------------------------------------------------------------
module sacache_set_mem (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    input  wire logic                            rd_en,
    input  wire logic [sacache_pkg::SET_W-1:0]   rd_addr,
    output sacache_pkg::set_line_t               rd_data,
    input  wire logic                            wr_en,
    input  wire logic [sacache_pkg::SET_W-1:0]   wr_addr,
    input  sacache_pkg::set_line_t               wr_data
);
    import sacache_pkg::*;

    localparam int ROW_W = MAX_WAYS * (ADDR_WIDTH + STAMP_W);

    logic [ROW_W-1:0]    mem [MAX_SETS];
    logic [MAX_WAYS-1:0] valid_reg [MAX_SETS];
    logic [ROW_W-1:0]    rd_row_reg;
    logic [MAX_WAYS-1:0] rd_valid_reg;
    logic [ROW_W-1:0]    wr_row;

    always_comb begin
        for (int w = 0; w < MAX_WAYS; w++) begin
            wr_row[w*(ADDR_WIDTH+STAMP_W) +: ADDR_WIDTH+STAMP_W] =
                {wr_data[w].tag, wr_data[w].stamp};
            rd_data[w].tag   = rd_row_reg[w*(ADDR_WIDTH+STAMP_W)+STAMP_W +: ADDR_WIDTH];
            rd_data[w].stamp = rd_valid_reg[w] ?
                rd_row_reg[w*(ADDR_WIDTH+STAMP_W) +: STAMP_W] : '0;
            rd_data[w].valid = rd_valid_reg[w];
        end
    end

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_row;
        end
        if (rd_en) begin
            rd_row_reg <= mem[rd_addr];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < MAX_SETS; i++) begin
                valid_reg[i] <= '0;
            end
            rd_valid_reg <= '0;
        end else begin
            if (wr_en) begin
                for (int w = 0; w < MAX_WAYS; w++) begin
                    valid_reg[wr_addr][w] <= wr_data[w].valid;
                end
            end
            if (rd_en) begin
                rd_valid_reg <= valid_reg[rd_addr];
            end
        end
    end

endmodule
`default_nettype wire

// File: rtl/core/set_assoc_cache_lru_fifo_prefetch_top.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Set-associative cache model, top level
// Write-through, write-allocate cache with FIFO or LRU replacement and
// next-line prefetch; reports hit, memory traffic and running totals.
// ----------------------------------------------------------------------------
// Channel    Direction  Ports
// access     in         s_valid, s_ready, s_operation, s_address
// result     out        m_valid, m_ready, m_hit ... m_write_total
// config     in         psel, penable, pwrite, paddr, pwdata, prdata, pready
//
// The result passes three steps after a transaction is accepted (read set,
// decide and write back, output); a prefetch on a miss with prefetch enabled
// adds a read and an update of a second set. A new transaction is accepted
// only in the idle state, once the previous result has reached the output
// register. Reset clears all valid bits at once; no clearing pass.
// A new transaction is taken while a finished result waits in the output
// register, and the core stalls only when that register is still full.
// ----------------------------------------------------------------------------
module set_assoc_cache_lru_fifo_prefetch_top (
    input  wire logic                               aclk,
    input  wire logic                               aresetn,
    input  wire logic                               s_valid,
    output logic                                    s_ready,
    input  wire logic                               s_operation,
    input  wire logic [sacache_pkg::ADDR_WIDTH-1:0] s_address,
    output logic                                    m_valid,
    input  wire logic                               m_ready,
    output logic                                    m_hit,
    output logic [1:0]                              m_mem_reads,
    output logic                                    m_mem_write,
    output logic [sacache_pkg::TOTAL_W-1:0]         m_hit_total,
    output logic [sacache_pkg::TOTAL_W-1:0]         m_miss_total,
    output logic [sacache_pkg::TOTAL_W-1:0]         m_read_total,
    output logic [sacache_pkg::TOTAL_W-1:0]         m_write_total,
    input  wire logic                               psel,
    input  wire logic                               penable,
    input  wire logic                               pwrite,
    input  wire logic [4:0]                         paddr,
    input  wire logic [31:0]                        pwdata,
    output logic [31:0]                             prdata,
    output logic                                    pready
);
    import sacache_pkg::*;

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_DEMR  = 3'd1;
    localparam logic [2:0] ST_DEMU  = 3'd2;
    localparam logic [2:0] ST_PFR   = 3'd3;
    localparam logic [2:0] ST_PFU   = 3'd4;
    localparam logic [2:0] ST_DONE  = 3'd5;

    cfg_t cfg;

    sacache_cfg u_cfg (
        .aclk, .aresetn, .psel, .penable, .pwrite, .paddr, .pwdata,
        .prdata, .pready, .cfg
    );

    logic [2:0]            state_reg, state_next;
    logic                  op_reg;
    logic [ADDR_WIDTH-1:0] addr_reg;
    logic                  hit_reg;
    logic [1:0]            reads_reg;
    logic [STAMP_W-1:0]    stamp_reg;
    logic [TOTAL_W-1:0]    hit_cnt_reg, miss_cnt_reg, read_cnt_reg, write_cnt_reg;
    logic                  out_valid_reg;

    logic [3:0]            b_eff;
    logic [2:0]            s_eff;
    logic [2:0]            w_eff;
    logic [ADDR_WIDTH-1:0] next_addr;
    logic [ADDR_WIDTH-1:0] cur_addr;
    logic [SET_W-1:0]      cur_set;
    logic [ADDR_WIDTH-1:0] cur_tag;
    logic [SET_W-1:0]      smask;

    logic                  rd_en, wr_en;
    logic [SET_W-1:0]      rd_addr;
    set_line_t             rd_data, wr_data;

    logic                  found;
    logic [WAY_W-1:0]      hit_way, victim;
    logic                  inv_found;
    logic [STAMP_W-1:0]    fresh_stamp;

    always_comb begin
        b_eff = (cfg.offset_bits > 4'(OFFS_MAX)) ? 4'(OFFS_MAX) : cfg.offset_bits;
        s_eff = (cfg.set_bits > 3'(SET_W)) ? 3'(SET_W) : cfg.set_bits;
        w_eff = (cfg.ways_in_use == 3'd0) ? 3'd1 :
                (cfg.ways_in_use > 3'(MAX_WAYS)) ? 3'(MAX_WAYS) : cfg.ways_in_use;
        smask = SET_W'((7'd1 << s_eff) - 7'd1);
        next_addr = addr_reg + (ADDR_WIDTH'(1) << b_eff);
    end

    wire pf_phase = (state_reg == ST_PFR) || (state_reg == ST_PFU);

    always_comb begin
        cur_addr = pf_phase ? next_addr : addr_reg;
        cur_set  = SET_W'(cur_addr >> b_eff) & smask;
        cur_tag  = cur_addr >> (5'(b_eff) + 5'(s_eff));
    end

    assign rd_en   = (state_reg == ST_DEMR) || (state_reg == ST_PFR);
    assign rd_addr = cur_set;

    always_comb begin
        found = 1'b0;
        hit_way = '0;
        inv_found = 1'b0;
        victim = '0;
        for (int w = MAX_WAYS - 1; w >= 0; w--) begin
            if (3'(w) < w_eff && rd_data[w].valid && rd_data[w].tag == cur_tag) begin
                found = 1'b1;
                hit_way = WAY_W'(w);
            end
            if (3'(w) < w_eff && !rd_data[w].valid) begin
                inv_found = 1'b1;
                victim = WAY_W'(w);
            end
        end
        if (!inv_found) begin
            victim = '0;
            for (int w = 1; w < MAX_WAYS; w++) begin
                if (3'(w) < w_eff && rd_data[w].stamp <= rd_data[victim].stamp) begin
                    victim = WAY_W'(w);
                end
            end
        end
        fresh_stamp = (stamp_reg == STAMP_MAX) ? stamp_reg : stamp_reg + 1'b1;
    end

    always_comb begin
        wr_data = rd_data;
        wr_en   = 1'b0;
        if (state_reg == ST_DEMU) begin
            if (found) begin
                wr_en = cfg.lru_mode;
                wr_data[hit_way].stamp = fresh_stamp;
            end else begin
                wr_en = 1'b1;
                wr_data[victim] = '{valid: 1'b1, tag: cur_tag, stamp: fresh_stamp};
            end
        end else if (state_reg == ST_PFU && !found) begin
            wr_en = 1'b1;
            wr_data[victim] = '{valid: 1'b1, tag: cur_tag, stamp: fresh_stamp};
        end
    end

    sacache_set_mem u_mem (
        .aclk, .aresetn, .rd_en, .rd_addr, .rd_data,
        .wr_en, .wr_addr(cur_set), .wr_data
    );

    assign s_ready = (state_reg == ST_IDLE);

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: if (s_valid) state_next = ST_DEMR;
            ST_DEMR: state_next = ST_DEMU;
            ST_DEMU: state_next = (!found && cfg.prefetch_enable) ? ST_PFR : ST_DONE;
            ST_PFR:  state_next = ST_PFU;
            ST_PFU:  state_next = ST_DONE;
            ST_DONE: if (!out_valid_reg || m_ready) state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            op_reg   <= s_operation;
            addr_reg <= s_address;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            stamp_reg     <= '0;
            hit_cnt_reg   <= '0;
            miss_cnt_reg  <= '0;
            read_cnt_reg  <= '0;
            write_cnt_reg <= '0;
            out_valid_reg <= 1'b0;
            hit_reg       <= 1'b0;
            reads_reg     <= '0;
        end else begin
            state_reg <= state_next;
            if (wr_en) begin
                stamp_reg <= fresh_stamp;
            end
            if (state_reg == ST_DEMU) begin
                hit_reg   <= found;
                reads_reg <= found ? 2'd0 : 2'd1;
                if (found) begin
                    hit_cnt_reg <= sat_inc(hit_cnt_reg);
                end else begin
                    miss_cnt_reg <= sat_inc(miss_cnt_reg);
                    read_cnt_reg <= sat_inc(read_cnt_reg);
                end
                if (op_reg) begin
                    write_cnt_reg <= sat_inc(write_cnt_reg);
                end
            end
            if (state_reg == ST_PFU && !found) begin
                reads_reg    <= 2'd2;
                read_cnt_reg <= sat_inc(read_cnt_reg);
            end
            if (m_valid && m_ready) begin
                out_valid_reg <= 1'b0;
            end
            if (state_reg == ST_DONE && (!out_valid_reg || m_ready)) begin
                out_valid_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (state_reg == ST_DONE && (!out_valid_reg || m_ready)) begin
            m_hit         <= hit_reg;
            m_mem_reads   <= reads_reg;
            m_mem_write   <= op_reg;
            m_hit_total   <= hit_cnt_reg;
            m_miss_total  <= miss_cnt_reg;
            m_read_total  <= read_cnt_reg;
            m_write_total <= write_cnt_reg;
        end
    end

    assign m_valid = out_valid_reg;

endmodule
`default_nettype wire
